/* src/tcw_pkg.sv */
// shared types and constants for the congestion window block
`default_nettype none

package tcw_pkg;

   localparam int WINDOW_MAX_DEFAULT = 65535;

   localparam logic [15:0] SERVER_WINDOW_RESET = 16'd16;
   localparam logic [15:0] CONG_WINDOW_RESET   = 16'd1;

   // event kinds
   localparam logic [1:0] MODE_NEW_ACK  = 2'd0;
   localparam logic [1:0] MODE_FAST_RTX = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] acked_count;
      logic [15:0] client_window;
      logic [15:0] in_flight;
   } tcw_req_type;

   typedef struct packed {
      logic [15:0] usable_window;
      logic [15:0] cong_window_out;
      logic [15:0] threshold_out;
   } tcw_rsp_type;

endpackage

`default_nettype wire

/* src/tcw_update.sv */
// window state registers and the per-event update logic
`default_nettype none

module tcw_update
   import tcw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cfg_write,
   input  wire logic [15:0] cfg_data,
   input  wire logic        advance,
   input  wire tcw_req_type item,
   output tcw_rsp_type      result
);

   localparam logic [15:0] WMAX = 16'(WINDOW_MAX);

   logic [15:0] server_window_ff;
   logic [15:0] cong_window_ff, cong_window_in;
   logic [15:0] ss_threshold_ff, ss_threshold_in;
   logic [15:0] ack_acc_ff, ack_acc_in;

   logic [15:0] acc_sum;
   logic [15:0] cw_sum;
   logic [15:0] half;
   logic [15:0] thr_loss;
   logic [15:0] avail;
   logic [15:0] usable;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum > {1'b0, WMAX}) begin
         return WMAX;
      end
      return sum[15:0];
   endfunction

   always_comb begin
      acc_sum  = sat_add(ack_acc_ff, item.acked_count);
      cw_sum   = sat_add(cong_window_ff, acc_sum);
      half     = {1'b0, cong_window_ff[15:1]};
      // unset threshold takes plain half, a set one floors at two
      if (ss_threshold_ff == 16'd0) begin
         thr_loss = half;
      end else if (half < 16'd2) begin
         thr_loss = 16'd2;
      end else begin
         thr_loss = half;
      end

      cong_window_in  = cong_window_ff;
      ss_threshold_in = ss_threshold_ff;
      ack_acc_in      = ack_acc_ff;
      case (item.mode)
         MODE_NEW_ACK: begin
            if (ss_threshold_ff == 16'd0) begin
               cong_window_in = cw_sum;
               ack_acc_in     = 16'd0;
            end else if (cong_window_ff < ss_threshold_ff) begin
               cong_window_in = (cw_sum < ss_threshold_ff) ? cw_sum : ss_threshold_ff;
               ack_acc_in     = 16'd0;
            end else if (acc_sum >= cong_window_ff) begin
               cong_window_in = sat_add(cong_window_ff, 16'd1);
               ack_acc_in     = 16'd0;
            end else begin
               ack_acc_in = acc_sum;
            end
         end
         MODE_FAST_RTX: begin
            ss_threshold_in = thr_loss;
            cong_window_in  = (half < 16'd1) ? 16'd1 : half;
            ack_acc_in      = 16'd0;
         end
         MODE_TIMEOUT: begin
            ss_threshold_in = thr_loss;
            cong_window_in  = 16'd1;
            ack_acc_in      = 16'd0;
         end
         default: begin
            // unused kind leaves the state alone
            cong_window_in  = cong_window_ff;
            ss_threshold_in = ss_threshold_ff;
            ack_acc_in      = ack_acc_ff;
         end
      endcase

      avail  = (item.in_flight > server_window_ff) ? 16'd0
                                                   : server_window_ff - item.in_flight;
      usable = (avail < item.client_window) ? avail : item.client_window;
      if (cong_window_in < usable) begin
         usable = cong_window_in;
      end

      result.usable_window   = usable;
      result.cong_window_out = cong_window_in;
      result.threshold_out   = ss_threshold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_window_ff <= SERVER_WINDOW_RESET;
         cong_window_ff   <= CONG_WINDOW_RESET;
         ss_threshold_ff  <= 16'd0;
         ack_acc_ff       <= 16'd0;
      end else begin
         if (cfg_write) begin
            server_window_ff <= cfg_data;
         end
         if (advance) begin
            cong_window_ff  <= cong_window_in;
            ss_threshold_ff <= ss_threshold_in;
            ack_acc_ff      <= ack_acc_in;
         end
      end
   end

endmodule

`default_nettype wire

/* src/tcp_congestion_window.sv */
// an accepted event goes through the input register, then the result register
// throughput: one event per cycle unless stalled; state updates as each result registers
// an event is held in the input register while the result register is full and stalled
// reset clears both stage valids, window to 1, threshold to unset, accumulator to 0
// reset sets the server window register to 16
`default_nettype none

module tcp_congestion_window
   import tcw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire tcw_req_type req_data,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output tcw_rsp_type      rsp_data,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   logic        s1_valid_ff;
   tcw_req_type s1_data_ff;
   logic        rsp_valid_ff;
   tcw_rsp_type rsp_data_ff;

   logic        out_load;
   logic        s1_load;
   tcw_rsp_type result;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_load;
   assign s1_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   tcw_update #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (csr_valid && csr_ready),
      .cfg_data  (csr_data),
      .advance   (s1_valid_ff && out_load),
      .item      (s1_data_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (out_load || !s1_valid_ff) begin
            s1_valid_ff <= s1_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
      if (out_load && s1_valid_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_valid_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.cong_window_out != 16'd0))
      else $error("congestion window dropped to zero");

   a_usable_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.usable_window <= rsp_data_ff.cong_window_out))
      else $error("usable window above congestion window");

   a_held_item_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_stall) |=> rsp_valid_ff)
      else $error("held transfer not moved to the result register");

endmodule

`default_nettype wire

/* bench/tcp_congestion_window_tb.sv */
// self-checking testbench for the tcp congestion window block
`timescale 1ns / 100ps

module tcp_congestion_window_tb
   import tcw_pkg::*;
();

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned WINDOW_MAX = WINDOW_MAX_DEFAULT;
   localparam int unsigned LONG_HOLD = 80;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   tcw_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   tcw_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // predicted block state
   int unsigned srv_window;
   int unsigned cwnd;
   int unsigned ssthresh;
   int unsigned acked_run;

   tcw_rsp_type window_q[$];
   int unsigned err_count;
   int unsigned rsp_count;
   int unsigned rsp_seen;
   int unsigned rx_wait;
   int unsigned hold_left;
   int unsigned hold_request;
   bit          tx_idle;
   bit          rx_idle;

   tcp_congestion_window dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned clip_window(input int unsigned v);
      return (v > WINDOW_MAX) ? WINDOW_MAX : v;
   endfunction

   // advances the window state by one event and returns the answer it gives
   function automatic tcw_rsp_type predict_window(input tcw_req_type ev);
      int unsigned half;
      int unsigned avail;
      int unsigned usable;
      tcw_rsp_type r;
      if (ev.mode != MODE_UNUSED) begin
         acked_run = clip_window(acked_run + 32'(ev.acked_count));
         half = cwnd >> 1;
         if (ev.mode == MODE_NEW_ACK) begin
            if (ssthresh == 0) begin
               cwnd = clip_window(cwnd + acked_run);
               acked_run = 0;
            end else if (cwnd < ssthresh) begin
               cwnd = clip_window(cwnd + acked_run);
               if (cwnd > ssthresh) cwnd = ssthresh;
               acked_run = 0;
            end else if (acked_run >= cwnd) begin
               cwnd = clip_window(cwnd + 1);
               acked_run = 0;
            end
         end else begin
            // unset threshold takes half with no floor, a set one floors at two
            ssthresh = (ssthresh == 0 || half >= 2) ? half : 2;
            if (ev.mode == MODE_FAST_RTX) cwnd = (half < 1) ? 1 : half;
            else cwnd = 1;
            acked_run = 0;
         end
      end
      avail = (32'(ev.in_flight) > srv_window) ? 0 : srv_window - 32'(ev.in_flight);
      usable = (avail < 32'(ev.client_window)) ? avail : 32'(ev.client_window);
      if (cwnd < usable) usable = cwnd;
      r.usable_window   = usable[15:0];
      r.cong_window_out = cwnd[15:0];
      r.threshold_out   = ssthresh[15:0];
      return r;
   endfunction

   function automatic tcw_req_type mk_event(input logic [1:0] mode, input int unsigned acked,
                                            input int unsigned client, input int unsigned flight);
      tcw_req_type ev;
      ev.mode          = mode;
      ev.acked_count   = acked[15:0];
      ev.client_window = client[15:0];
      ev.in_flight     = flight[15:0];
      return ev;
   endfunction

   // mostly well-formed ack traffic with small counts, a share of losses and wild values
   function automatic tcw_req_type random_event();
      int unsigned pick;
      int unsigned acked;
      int unsigned client;
      int unsigned flight;
      logic [1:0]  mode;
      pick = $urandom_range(0, 99);
      if (pick < 70) mode = MODE_NEW_ACK;
      else if (pick < 82) mode = MODE_FAST_RTX;
      else if (pick < 94) mode = MODE_TIMEOUT;
      else mode = MODE_UNUSED;
      case ($urandom_range(0, 9))
         0: acked = $urandom_range(0, 65535);
         1: acked = 65535;
         default: acked = $urandom_range(0, 8);
      endcase
      case ($urandom_range(0, 5))
         0: client = $urandom_range(0, 65535);
         1: client = 65535;
         2: client = 0;
         default: client = $urandom_range(0, 64);
      endcase
      case ($urandom_range(0, 5))
         0: flight = $urandom_range(0, 65535);
         1: flight = 65535;
         default: flight = $urandom_range(0, srv_window);
      endcase
      return mk_event(mode, acked, client, flight);
   endfunction

   task automatic send_event(input tcw_req_type ev);
      int unsigned gap;
      gap = tx_idle ? $urandom_range(0, 9) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      window_q.push_back(predict_window(ev));
   endtask

   // drop valid and wait until every expected result has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (window_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_server_window(input logic [15:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      srv_window = 32'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         // switch idling on and off in stretches
         if (i % 60 == 0) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
         end
         send_event(random_event());
      end
   endtask

   // walks the window through slow start, avoidance, both losses and saturation
   task automatic test_directed();
      tcw_req_type evs[$];
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      evs.push_back(mk_event(MODE_UNUSED,   500,   65535, 0));
      evs.push_back(mk_event(MODE_FAST_RTX, 0,     65535, 0));
      evs.push_back(mk_event(MODE_TIMEOUT,  0,     65535, 3));
      evs.push_back(mk_event(MODE_NEW_ACK,  0,     65535, 0));
      evs.push_back(mk_event(MODE_NEW_ACK,  5,     0,     0));
      evs.push_back(mk_event(MODE_NEW_ACK,  65535, 65535, 0));
      evs.push_back(mk_event(MODE_NEW_ACK,  65535, 7,     20));
      evs.push_back(mk_event(MODE_FAST_RTX, 65535, 65535, 16));
      evs.push_back(mk_event(MODE_NEW_ACK,  100,   65535, 65535));
      evs.push_back(mk_event(MODE_NEW_ACK,  65535, 65535, 1));
      evs.push_back(mk_event(MODE_TIMEOUT,  65535, 65535, 0));
      evs.push_back(mk_event(MODE_NEW_ACK,  3,     65535, 15));
      evs.push_back(mk_event(MODE_NEW_ACK,  65535, 12,    2));
      evs.push_back(mk_event(MODE_TIMEOUT,  0,     65535, 0));
      evs.push_back(mk_event(MODE_FAST_RTX, 0,     65535, 0));
      evs.push_back(mk_event(MODE_NEW_ACK,  1,     65535, 0));
      evs.push_back(mk_event(MODE_NEW_ACK,  1,     65535, 0));
      evs.push_back(mk_event(MODE_NEW_ACK,  1,     65535, 0));
      evs.push_back(mk_event(MODE_UNUSED,   65535, 43690, 21845));
      evs.push_back(mk_event(MODE_NEW_ACK,  43690, 21845, 43690));
      foreach (evs[i]) send_event(evs[i]);
   endtask

   task automatic test_default_window();
      run_random(300);
   endtask

   task automatic test_window_extremes();
      set_server_window(16'hffff);
      run_random(350);
      set_server_window(16'h0000);
      run_random(100);
   endtask

   task automatic test_random_windows();
      repeat (3) begin
         set_server_window(16'($urandom_range(1, 200)));
         run_random(200);
      end
   endtask

   // receiver holds off long enough that both stages fill and the input stalls
   task automatic test_backpressure();
      set_server_window(16'd1000);
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      hold_request = LONG_HOLD;
      repeat (40) send_event(random_event());
      // sender pauses until everything has come back
      wait_drained();
      tx_idle = 1'b1;
      repeat (20) send_event(random_event());
   endtask

   // receiver side: per result a random wait, plus the occasional long hold
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rx_wait != 0) begin
            rsp_stall <= 1'b1;
            rx_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      tcw_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (window_q.size() == 0) begin
            $error("result transfer with no expectation pending");
            err_count++;
         end else begin
            exp_rsp = window_q.pop_front();
            if (rsp_data.usable_window !== exp_rsp.usable_window) begin
               $error("usable_window: expected %0d, got %0d",
                      exp_rsp.usable_window, rsp_data.usable_window);
               err_count++;
            end
            if (rsp_data.cong_window_out !== exp_rsp.cong_window_out) begin
               $error("cong_window_out: expected %0d, got %0d",
                      exp_rsp.cong_window_out, rsp_data.cong_window_out);
               err_count++;
            end
            if (rsp_data.threshold_out !== exp_rsp.threshold_out) begin
               $error("threshold_out: expected %0d, got %0d",
                      exp_rsp.threshold_out, rsp_data.threshold_out);
               err_count++;
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("tcp_congestion_window_tb NOT OK");
      $finish;
   end

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      err_count    = 0;
      rsp_count    = 0;
      rsp_seen     = 0;
      rx_wait      = 0;
      hold_left    = 0;
      hold_request = 0;
      tx_idle      = 1'b1;
      rx_idle      = 1'b1;
      srv_window   = 32'(SERVER_WINDOW_RESET);
      cwnd         = 32'(CONG_WINDOW_RESET);
      ssthresh     = 0;
      acked_run    = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_default_window();
      test_window_extremes();
      test_random_windows();
      test_backpressure();

      wait_drained();
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("tcp_congestion_window_tb OK");
      end else begin
         $display("tcp_congestion_window_tb NOT OK");
      end
      $finish;
   end

endmodule
